// ----- rtl/ioovr_pkg.sv -----
// ----------------------------------------------------------------------------
// ioovr_pkg - IO control override table shared definitions
// Error codes, control modes, the value clamp and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package ioovr_pkg;

	// negative response codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_CONDITIONS = 3'd1;
	localparam logic [2:0] ERR_LENGTH     = 3'd2;
	localparam logic [2:0] ERR_RANGE      = 3'd3;
	localparam logic [2:0] ERR_SECURITY   = 3'd4;

	// control modes
	localparam logic [7:0] MODE_RETURN = 8'd0;
	localparam logic [7:0] MODE_RESET  = 8'd1;
	localparam logic [7:0] MODE_FREEZE = 8'd2;
	localparam logic [7:0] MODE_ADJUST = 8'd3;

	// largest number of stored parameter bytes
	localparam logic [3:0] VALUE_BYTES = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the request
		logic check;     // register verdict and response payload
		logic scan_clr;  // restart the table scan
		logic scan_run;  // step the table scan
		logic update;    // apply the table change
		logic emit;      // present the result
	} ioovr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go_resp;   // no table work needed
		logic scan_done; // last slot compared
	} ioovr_sts_t;

	// keep the top n bytes of a 64-bit word
	function automatic logic [63:0] top_bytes_mask(input logic [3:0] n);
		logic [3:0] k;
		logic [6:0] sh;
		k = (n > 4'd8) ? 4'd8 : n;
		sh = {k, 3'b000};
		if (k == 4'd0) begin
			top_bytes_mask = 64'd0;
		end else begin
			top_bytes_mask = ~64'd0 << (7'd64 - sh);
		end
	endfunction

endpackage

// ----- rtl/ioovr_ram.sv -----
// ----------------------------------------------------------------------------
// ioovr_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ioovr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ioovr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ioovr_ctrl - request sequencer
// Steps each item: capture, checks, table scan and update if needed, result.
// ----------------------------------------------------------------------------
module ioovr_ctrl
	import ioovr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  ioovr_sts_t sts,
	output ioovr_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = sts.go_resp ? ST_RESP : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/ioovr_dp.sv -----
// ----------------------------------------------------------------------------
// ioovr_dp - request checks and override table datapath
// Holds the captured item, the check verdict, the slot scan and the result.
// ----------------------------------------------------------------------------
module ioovr_dp
	import ioovr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ioovr_cmd_t  cmd,
	output ioovr_sts_t  sts,
	input  logic        context_present,
	input  logic        unlocked,
	input  logic [7:0]  req_len,
	input  logic [15:0] did,
	input  logic [7:0]  op_mode,
	input  logic [63:0] param_bytes,
	input  logic        did_known,
	input  logic        did_secured,
	input  logic        read_ok,
	input  logic [63:0] current_value,
	input  logic [3:0]  current_len,
	input  logic        suppress_positive,
	output logic        done,
	output logic        negative,
	output logic [2:0]  error_code,
	output logic [15:0] resp_did,
	output logic [1:0]  resp_mode,
	output logic [63:0] payload,
	output logic [3:0]  payload_len
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	// captured item
	logic        ctx_q, unl_q, known_q, sec_q, rok_q, sup_q;
	logic [7:0]  dlen_q, mode_q;
	logic [15:0] did_q;
	logic [63:0] par_q, cur_q;
	logic [3:0]  clen_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ctx_q   <= context_present;
			unl_q   <= unlocked;
			dlen_q  <= req_len;
			did_q   <= did;
			mode_q  <= op_mode;
			par_q   <= param_bytes;
			known_q <= did_known;
			sec_q   <= did_secured;
			rok_q   <= read_ok;
			cur_q   <= current_value;
			clen_q  <= current_len;
			sup_q   <= suppress_positive;
		end
	end

	// checks in priority order
	logic [2:0]  chk_err;
	logic [7:0]  plen_raw;
	logic [3:0]  plen, clen;
	logic [63:0] chk_pay;
	logic [3:0]  chk_len;
	logic        is_remove, is_freeze, is_adjust;

	assign is_remove = (mode_q == MODE_RETURN) || (mode_q == MODE_RESET);
	assign is_freeze = (mode_q == MODE_FREEZE);
	assign is_adjust = (mode_q == MODE_ADJUST);

	always_comb begin
		chk_err = ERR_NONE;
		if (!ctx_q) begin
			chk_err = ERR_CONDITIONS;
		end else if (dlen_q < 8'd2) begin
			chk_err = ERR_LENGTH;
		end else if (!known_q) begin
			chk_err = ERR_RANGE;
		end else if (mode_q > MODE_ADJUST) begin
			chk_err = ERR_RANGE;
		end else if (sec_q && !unl_q) begin
			chk_err = ERR_SECURITY;
		end else if (is_remove) begin
			if (dlen_q != 8'd2) chk_err = ERR_LENGTH;
		end else if (is_freeze) begin
			if (dlen_q != 8'd2) chk_err = ERR_LENGTH;
			else if (!rok_q) chk_err = ERR_RANGE;
		end else if (dlen_q < 8'd3) begin
			chk_err = ERR_LENGTH;
		end
	end

	// response payload: frozen value or clamped parameters
	assign plen_raw = dlen_q - 8'd2;
	assign plen = (plen_raw > {4'd0, VALUE_BYTES}) ? VALUE_BYTES : plen_raw[3:0];
	assign clen = (clen_q > 4'd8) ? 4'd8 : clen_q;

	always_comb begin
		chk_pay = 64'd0;
		chk_len = 4'd0;
		if (is_freeze) begin
			chk_pay = cur_q & top_bytes_mask(clen);
			chk_len = clen;
		end else if (is_adjust) begin
			chk_pay = par_q & top_bytes_mask(plen);
			chk_len = plen;
		end
	end

	assign sts.go_resp = (chk_err != ERR_NONE) || is_freeze;

	// slot scan, one slot a cycle through the identifier RAM
	logic [IDX_W-1:0] cnt_q, idx_s1, match_q, free_idx_q;
	logic             issue_q, valid_s1, found_q, free_q;
	logic [15:0]      rd_did;
	logic             active_q [TABLE_ENTRIES];
	logic             ram_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			issue_q  <= 1'b0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
		end else if (cmd.scan_clr) begin
			cnt_q    <= '0;
			issue_q  <= 1'b1;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_run && issue_q;
			if (cmd.scan_run && issue_q) begin
				issue_q <= (cnt_q != LAST);
				if (cnt_q != LAST) cnt_q <= cnt_q + 1'b1;
			end
			// first active match and first free slot
			if (valid_s1) begin
				if (active_q[idx_s1] && rd_did == did_q && !found_q) begin
					found_q <= 1'b1;
				end
				if (!active_q[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (valid_s1 && active_q[idx_s1] && rd_did == did_q && !found_q) begin
			match_q <= idx_s1;
		end
		if (valid_s1 && !active_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign sts.scan_done = valid_s1 && (idx_s1 == LAST);

	// table change: remove, claim a slot, or table full
	assign ram_we = cmd.update && is_adjust && !found_q && free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) active_q[i] <= 1'b0;
		end else if (cmd.update) begin
			if (is_remove && found_q) active_q[match_q] <= 1'b0;
			if (ram_we) active_q[free_idx_q] <= 1'b1;
		end
	end

	// override values are never read back, so only identifiers are kept
	ioovr_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_did_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata (did_q),
		.raddr (cnt_q),
		.rdata (rd_did)
	);

	// verdict and response
	logic [2:0]  err_q;
	logic [63:0] pay_q;
	logic [3:0]  plen_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			err_q  <= chk_err;
			pay_q  <= chk_pay;
			plen_q <= chk_len;
		end else if (cmd.update && is_adjust && !found_q && !free_q) begin
			err_q <= ERR_RANGE;
		end
	end

	// result registers, strobe for one cycle
	logic neg;
	assign neg = (err_q != ERR_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit && (neg || !sup_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			negative    <= neg;
			error_code  <= err_q;
			resp_did    <= neg ? 16'd0 : did_q;
			resp_mode   <= neg ? 2'd0 : mode_q[1:0];
			payload     <= neg ? 64'd0 : pay_q;
			payload_len <= neg ? 4'd0 : plen_q;
		end
	end

endmodule

// ----- rtl/io_control_override_table_unit.sv -----
// ----------------------------------------------------------------------------
// io_control_override_table_unit - IO control request handler
// Checks one diagnostic IO control request and maintains the override table.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on the input ports and raise start; it is taken at the
//   clock edge where start is high and busy is low. busy stays high until the
//   item is finished.
//   A result appears on the result ports for one cycle with done high. A
//   suppressed positive answer gives no done pulse. The receiver cannot
//   stall; the result is gone after that cycle.
//   Order: a request rejected by the checks, or a freeze, goes from capture
//   through the checks straight to its result. Return, reset-default and
//   adjust requests that pass the checks scan the table one slot a cycle
//   through the identifier RAM read port and update it before the result.
//   A new item may start in the cycle the result is shown.
//   Reset: arst_n clears the sequencer, the strobe and every slot's active
//   flag at once, so the table is empty with no clearing pass.
// ----------------------------------------------------------------------------
module io_control_override_table_unit
	import ioovr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        context_present,
	input  logic        unlocked,
	input  logic [7:0]  req_len,
	input  logic [15:0] did,
	input  logic [7:0]  op_mode,
	input  logic [63:0] param_bytes,
	input  logic        did_known,
	input  logic        did_secured,
	input  logic        read_ok,
	input  logic [63:0] current_value,
	input  logic [3:0]  current_len,
	input  logic        suppress_positive,
	output logic        done,
	output logic        negative,
	output logic [2:0]  error_code,
	output logic [15:0] resp_did,
	output logic [1:0]  resp_mode,
	output logic [63:0] payload,
	output logic [3:0]  payload_len
);

	ioovr_cmd_t cmd;
	ioovr_sts_t sts;

	// sequencer
	ioovr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// checks and table
	ioovr_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.context_present   (context_present),
		.unlocked          (unlocked),
		.req_len           (req_len),
		.did               (did),
		.op_mode           (op_mode),
		.param_bytes       (param_bytes),
		.did_known         (did_known),
		.did_secured       (did_secured),
		.read_ok           (read_ok),
		.current_value     (current_value),
		.current_len       (current_len),
		.suppress_positive (suppress_positive),
		.done              (done),
		.negative          (negative),
		.error_code        (error_code),
		.resp_did          (resp_did),
		.resp_mode         (resp_mode),
		.payload           (payload),
		.payload_len       (payload_len)
	);

endmodule

// ----- rtl/ioovr_chk.sv -----
// ----------------------------------------------------------------------------
// ioovr_chk - port level checks for the IO control override table
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module ioovr_chk
	import ioovr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        negative,
	input logic [2:0]  error_code,
	input logic [15:0] resp_did,
	input logic [3:0]  payload_len
);

	// an accepted item keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after accepting an item");

	// a result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a result ends the item: the unit is free while it is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// the code agrees with the response polarity
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (negative == (error_code != ERR_NONE)))
		else $error("error code does not match response polarity");

	// a negative response carries no echo
	a_neg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && negative |-> (resp_did == 16'd0) && (payload_len == 4'd0))
		else $error("negative response carries echoed fields");

endmodule

bind io_control_override_table_unit ioovr_chk u_ioovr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.negative    (negative),
	.error_code  (error_code),
	.resp_did    (resp_did),
	.payload_len (payload_len)
);
